@@ rtl/in_order_completion_tracker_macros.svh @@
// Assertion macros for the in-order completion tracker.
`ifndef IN_ORDER_COMPLETION_TRACKER_MACROS_SVH
`define IN_ORDER_COMPLETION_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define IOCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define IOCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define IOCT_ASSERT(lbl, prop, msg)
`define IOCT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/ioct_pkg.sv @@
// Shared constants, types and helpers of the in-order completion tracker.
package ioct_pkg;

  localparam int NUM_ITEMS = 1024;
  localparam int ITEM_W    = 11;
  localparam int LEN_W     = 11;
  localparam int WORD_W    = 32;
  localparam int OFF_W     = $clog2(WORD_W);
  localparam int RUN_W     = OFF_W + 1;
  localparam int NUM_WORDS = (NUM_ITEMS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = ADDR_W + OFF_W;
  localparam int PTR_W     = $clog2(NUM_ITEMS + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BIT_W-1:0]  bit_idx_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [RUN_W-1:0]  run_t;

  // Request from the sequencer to the map memory
  typedef struct packed {
    logic  re;
    addr_t raddr;
    logic  we;
    addr_t waddr;
    word_t wdata;
  } mem_req_t;

  // Length of the run of ones starting at bit 0 (WORD_W when all set)
  function automatic run_t ones_run(word_t w);
    word_t z;
    word_t lsb;
    run_t  pos;
    z   = ~w;
    lsb = z & (~z + word_t'(1));
    pos = '0;
    if (z == '0) begin
      pos = run_t'(WORD_W);
    end else begin
      for (int i = 0; i < WORD_W; i++) begin
        if (lsb[i]) begin
          pos = pos | run_t'(i);
        end
      end
    end
    return pos;
  endfunction

endpackage

@@ rtl/in_order_completion_tracker.sv @@
// Top level of the in-order completion tracker.
//
// Each beat taken (start high while busy is low) names one arrived item
// 1..NUM_ITEMS; exactly one result follows on done_o for a single cycle with
// the longest fully received prefix and a reject flag, and must be taken
// then, as the block cannot hold it. An out-of-range number answers in the next
// cycle. A valid number that does not extend the prefix takes one read and one
// write-back of its 32-bit bitmap word. A number that lands on the pointer adds,
// after the write-back, an evaluation of the forwarded word and then a read and
// an evaluation for every further bitmap word the pointer runs into; the total
// scan work over all items is bounded by NUM_ITEMS/32 words. The map needs no
// clearing pass after reset: per-word valid bits make unwritten words read as
// empty.
module in_order_completion_tracker
  import ioct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ITEM_W-1:0] item_number_i,
  output logic              done_o,
  output logic [LEN_W-1:0]  prefix_length_o,
  output logic              rejected_o
);

`include "in_order_completion_tracker_macros.svh"

  mem_req_t mem_req;
  word_t    mem_rdata;

  // Sequencer
  ioct_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .item_number_i   (item_number_i),
    .busy_o          (busy),
    .done_o          (done_o),
    .prefix_length_o (prefix_length_o),
    .rejected_o      (rejected_o),
    .req_o           (mem_req),
    .rdata_i         (mem_rdata)
  );

  // Received bitmap
  ioct_map_mem u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Checks
  `IOCT_ASSERT(a_prefix_monotonic, prefix_length_o >= $past(prefix_length_o), "prefix shrank")
  `IOCT_ASSERT(a_prefix_bound, 32'(prefix_length_o) <= 32'(NUM_ITEMS), "prefix too long")
  `IOCT_ASSERT_IMP(a_reject_one_cycle, done_o && rejected_o, $past(start && !busy), "late reject")
  `IOCT_ASSERT_IMP(a_no_write_when_idle, !busy, !mem_req.we, "map write while idle")

endmodule

@@ rtl/ioct_map_mem.sv @@
// Received-item bitmap memory, one word per row, with per-row valid bits.
module ioct_map_mem
  import ioct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output word_t    rdata_o
);

  word_t                mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_vld_q;
  word_t                rdata_q;
  logic                 rvld_q;

  // Row valid bits: a row never written reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= row_vld_q[req_i.raddr];
      end
    end
  end

  // Storage array, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/ioct_ctrl.sv @@
// Sequencer: read-modify-write of the bitmap and word-wise prefix scan.
module ioct_ctrl
  import ioct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ITEM_W-1:0] item_number_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [LEN_W-1:0]  prefix_length_o,
  output logic              rejected_o,
  output mem_req_t          req_o,
  input  word_t             rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITEM,
    S_SCAN_RD,
    S_SCAN_EV
  } state_e;

  state_e   state_q, state_d;
  ptr_t     ptr_q, ptr_d;
  bit_idx_t idx_q, idx_d;
  word_t    word_q, word_d;
  logic     fwd_q, fwd_d;
  logic     done_q, done_d;
  logic     rej_q, rej_d;

  logic     item_bad;
  bit_idx_t item_idx;
  bit_idx_t ptr_idx;
  word_t    mod_word;
  word_t    scan_word;
  word_t    shifted;
  run_t     run;
  run_t     end_run;
  ptr_t     ptr_sum;
  logic     ptr_full;

  // Datapath: item decode, bit set, run search from the pointer
  assign item_bad  = (item_number_i == '0) || (32'(item_number_i) > 32'(NUM_ITEMS));
  assign item_idx  = BIT_W'(item_number_i - ITEM_W'(1));
  assign ptr_idx   = BIT_W'(ptr_q);
  assign ptr_full  = (ptr_q == PTR_W'(NUM_ITEMS));
  assign mod_word  = rdata_i | (word_t'(1) << idx_q[OFF_W-1:0]);
  assign scan_word = fwd_q ? word_q : rdata_i;
  assign shifted   = scan_word >> ptr_idx[OFF_W-1:0];
  assign run       = ones_run(shifted);
  assign end_run   = run_t'(WORD_W) - run_t'(ptr_idx[OFF_W-1:0]);
  assign ptr_sum   = ptr_q + PTR_W'(run);

  // Next-state logic
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    idx_d   = idx_q;
    word_d  = word_q;
    fwd_d   = fwd_q;
    done_d  = 1'b0;
    rej_d   = rej_q;
    req_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (item_bad) begin
            done_d = 1'b1;
            rej_d  = 1'b1;
          end else begin
            req_o.re    = 1'b1;
            req_o.raddr = item_idx[BIT_W-1:OFF_W];
            idx_d       = item_idx;
            state_d     = S_ITEM;
          end
        end
      end
      S_ITEM: begin
        req_o.we    = 1'b1;
        req_o.waddr = idx_q[BIT_W-1:OFF_W];
        req_o.wdata = mod_word;
        // Only an arrival at the pointer can move it
        if (!ptr_full && (idx_q == ptr_idx)) begin
          word_d  = mod_word;
          fwd_d   = 1'b1;
          state_d = S_SCAN_EV;
        end else begin
          done_d  = 1'b1;
          rej_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        req_o.re    = 1'b1;
        req_o.raddr = ptr_idx[BIT_W-1:OFF_W];
        fwd_d       = 1'b0;
        state_d     = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        ptr_d = ptr_sum;
        if ((run == end_run) && (ptr_sum != PTR_W'(NUM_ITEMS))) begin
          state_d = S_SCAN_RD;
        end else begin
          done_d  = 1'b1;
          rej_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      fwd_q   <= 1'b0;
      done_q  <= 1'b0;
      rej_q   <= 1'b0;
      idx_q   <= '0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fwd_q   <= fwd_d;
      done_q  <= done_d;
      rej_q   <= rej_d;
      idx_q   <= idx_d;
      word_q  <= word_d;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign rejected_o      = rej_q;
  assign prefix_length_o = LEN_W'(ptr_q);

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the in-order completion tracker.
`timescale 1ns / 100ps

module testbench
  import ioct_pkg::*;
();

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 7;
  localparam int RANDOM_NUM  = 400;
  localparam int DRAIN_CYC   = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 7;
  localparam int MAX_ITEM_NO = (1 << ITEM_W) - 1;

  typedef struct packed {
    logic [LEN_W-1:0] prefix_length;
    logic             rejected;
  } tracker_result_t;

  // Mirror of the received map and the prefix pointer, with in-order expectations
  class prefix_scoreboard;
    bit              received[NUM_ITEMS];
    int unsigned     prefix_ptr;
    tracker_result_t expected_q[$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     rejects;

    function new();
      prefix_ptr = 0;
      errors     = 0;
      checked    = 0;
      rejects    = 0;
      foreach (received[i]) received[i] = 1'b0;
    endfunction

    // Apply one accepted arrival and queue the result it must produce
    function void note_arrival(logic [ITEM_W-1:0] num);
      tracker_result_t res;
      res.rejected = (num == '0) || (int'(num) > NUM_ITEMS);
      if (res.rejected) begin
        rejects++;
      end else begin
        received[int'(num) - 1] = 1'b1;
        while (prefix_ptr < NUM_ITEMS && received[prefix_ptr]) prefix_ptr++;
      end
      res.prefix_length = LEN_W'(prefix_ptr);
      expected_q.push_back(res);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(logic [LEN_W-1:0] len, logic rej);
      tracker_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: prefix_length=%0d rejected=%0b", len, rej);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (len !== exp_res.prefix_length) begin
        $error("prefix_length: expected %0d, got %0d", exp_res.prefix_length, len);
        errors++;
      end
      if (rej !== exp_res.rejected) begin
        $error("rejected: expected %0b, got %0b", exp_res.rejected, rej);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ITEM_W-1:0] item_number_i = '0;
  logic              done_o;
  logic [LEN_W-1:0]  prefix_length_o;
  logic              rejected_o;

  prefix_scoreboard tracker = new();
  int unsigned      cycle_count = 0;

  in_order_completion_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_number_i  (item_number_i),
    .done_o         (done_o),
    .prefix_length_o(prefix_length_o),
    .rejected_o     (rejected_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Result monitor: done_o marks a beat that must be taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tracker.check_result(prefix_length_o, rejected_o);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drive one arrival beat, with an optional random idle gap before it
  task automatic send_item(input logic [ITEM_W-1:0] num, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    item_number_i <= num;
    do @(posedge clk_i); while (busy);
    tracker.note_arrival(num);
  endtask

  // Random arrival, mostly in a window just ahead of the prefix
  function automatic logic [ITEM_W-1:0] pick_item(int unsigned window);
    int unsigned sel;
    int unsigned num;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      num = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(NUM_ITEMS + 1, MAX_ITEM_NO);
    end else if (sel < 15) begin
      num = (tracker.prefix_ptr > 0) ? $urandom_range(1, tracker.prefix_ptr) : 1;
    end else if (sel < 25) begin
      num = $urandom_range(1, NUM_ITEMS);
    end else begin
      num = tracker.prefix_ptr + 1 + $urandom_range(0, window);
      if (num > NUM_ITEMS) num = $urandom_range(1, NUM_ITEMS);
    end
    return ITEM_W'(num);
  endfunction

  initial begin
    int unsigned directed[$];
    int unsigned window;
    bit          idle_ok;

    // Zero, top code, just over range, top valid, repeats, gap fills
    directed = '{0, MAX_ITEM_NO, NUM_ITEMS + 1, NUM_ITEMS, 1, 1, 3, 2, 6, 5, 4,
                 40, NUM_ITEMS - 1, NUM_ITEMS, 0, 7};

    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(ITEM_W'(directed[i]), 1'b1);

    window = 3;
    for (int n = 0; n < RANDOM_NUM; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: window = 3;
          1: window = 40;
          default: window = 100;
        endcase
      end
      // Back-to-back stretch in the middle of the run
      idle_ok = (n < 150) || (n >= 250);
      send_item(pick_item(window), idle_ok);
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Checked %0d results, %0d of them out-of-range arrivals.",
             tracker.checked, tracker.rejects);
    $display("Received prefix ended at %0d of %0d items.", tracker.prefix_ptr, NUM_ITEMS);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ioct_pkg.sv
rtl/ioct_map_mem.sv
rtl/ioct_ctrl.sv
rtl/in_order_completion_tracker.sv
tb/testbench.sv
